@@ rtl/core/tod_pkg.sv @@
`default_nettype none

package tod_pkg;

    localparam int unsigned AXIS_W    = 16;
    localparam int unsigned THRESH_W  = 15;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = THRESH_W;

    // Reset values of the configuration registers
    localparam logic [THRESH_W-1:0] TILT_THRESH_RST   = 15'd11500;
    localparam logic [THRESH_W-1:0] UPSIDE_THRESH_RST = 15'd8000;
    localparam logic [COUNT_W-1:0]  CONFIRM_CNT_RST   = 4'd4;

    // Filter sum 7*old + 3*sample is at most 10 * 2^15 in magnitude
    localparam int unsigned SUM_W = AXIS_W + 4;
    localparam int unsigned MAG_W = SUM_W - 1;

    // Divide by ten: q = (m * ceil(2^22 / 10)) >> 22, exact for m < 2^19
    localparam int unsigned DIV10_SHIFT = 22;
    localparam logic [MAG_W-1:0] DIV10_MULT = 19'd419431;
    localparam int unsigned PROD_W = 2 * MAG_W;

    typedef enum logic [1:0] {
        ORIENT_LANDSCAPE = 2'd0,
        ORIENT_POS_SIDE  = 2'd1,
        ORIENT_NEG_SIDE  = 2'd2,
        ORIENT_UPSIDE    = 2'd3
    } t_orient;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_THRESH   = 2'd0,
        CFG_UPSIDE_THRESH = 2'd1,
        CFG_CONFIRM_CNT   = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

@@ rtl/core/tod_sample_if.sv @@
`default_nettype none

interface tod_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [tod_pkg::AXIS_W-1:0]   accel_x;
    logic signed [tod_pkg::AXIS_W-1:0]   accel_y;
    logic signed [tod_pkg::AXIS_W-1:0]   accel_z;

    modport source (output valid, output accel_x, output accel_y, output accel_z,
                    input ready);
    modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/core/tod_result_if.sv @@
`default_nettype none

interface tod_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [tod_pkg::AXIS_W-1:0]   smooth_x;
    logic signed [tod_pkg::AXIS_W-1:0]   smooth_y;
    logic signed [tod_pkg::AXIS_W-1:0]   smooth_z;
    logic [1:0]                          candidate;
    logic                                commit;

    modport source (output valid, output smooth_x, output smooth_y, output smooth_z,
                    output candidate, output commit, input ready);
    modport sink   (input valid, input smooth_x, input smooth_y, input smooth_z,
                    input candidate, input commit, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tod_axis_filter.sv @@
`default_nettype none

// One low-pass step: (old*7 + sample*3) / 10, truncated toward zero.
module tod_axis_filter (
    input  wire logic signed [tod_pkg::AXIS_W-1:0] i_old,
    input  wire logic signed [tod_pkg::AXIS_W-1:0] i_sample,
    output logic signed [tod_pkg::AXIS_W-1:0]      o_new
);
    logic signed [tod_pkg::SUM_W-1:0]  w_old_ext;
    logic signed [tod_pkg::SUM_W-1:0]  w_smp_ext;
    logic signed [tod_pkg::SUM_W-1:0]  w_sum;
    logic signed [tod_pkg::SUM_W-1:0]  w_sum_neg;
    logic        [tod_pkg::MAG_W-1:0]  w_mag;
    logic        [tod_pkg::PROD_W-1:0] w_prod;
    logic        [tod_pkg::AXIS_W-1:0] w_quot;

    assign w_old_ext = tod_pkg::SUM_W'(i_old);
    assign w_smp_ext = tod_pkg::SUM_W'(i_sample);

    // 7*old = 8*old - old, 3*sample = 2*sample + sample
    assign w_sum = (w_old_ext <<< 3) - w_old_ext + (w_smp_ext <<< 1) + w_smp_ext;
    assign w_sum_neg = -w_sum;
    assign w_mag = w_sum[tod_pkg::SUM_W-1] ? w_sum_neg[tod_pkg::MAG_W-1:0]
                                           : w_sum[tod_pkg::MAG_W-1:0];

    assign w_prod = tod_pkg::PROD_W'(w_mag) * tod_pkg::PROD_W'(tod_pkg::DIV10_MULT);
    assign w_quot = w_prod[tod_pkg::DIV10_SHIFT +: tod_pkg::AXIS_W];

    // Restore the sign after dividing the magnitude
    assign o_new = w_sum[tod_pkg::SUM_W-1] ? -$signed(w_quot) : $signed(w_quot);
endmodule

`default_nettype wire

@@ rtl/core/tilt_orientation_detector_core.sv @@
// The edge that accepts a sample request loads the input register; then the filter
// state and result registers follow in that order.
// Throughput: one sample per cycle; a stalled result backs up the pipe.
// Reset (synchronous, active low): clear filter and debounce state,
// empty the pipe, load the configuration registers with their defaults.
`default_nettype none

module tilt_orientation_detector_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [tod_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [tod_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    tod_sample_if.sink                              i_sample,
    tod_result_if.source                            o_result
);
    // Configuration registers
    logic [tod_pkg::THRESH_W-1:0] r_tilt_thresh;
    logic [tod_pkg::THRESH_W-1:0] r_upside_thresh;
    logic [tod_pkg::COUNT_W-1:0]  r_confirm_cnt;

    // Stage 1: raw sample register
    logic                               r_s1_valid;
    logic signed [tod_pkg::AXIS_W-1:0]  r_s1_x, r_s1_y, r_s1_z;

    // Stage 2: filter state; while r_s2_valid it is also the stage payload
    logic                               r_s2_valid;
    logic signed [tod_pkg::AXIS_W-1:0]  r_filt_x, r_filt_y, r_filt_z;
    logic signed [tod_pkg::AXIS_W-1:0]  n_filt_x, n_filt_y, n_filt_z;

    // Debounce state
    tod_pkg::t_orient                   r_pending;
    tod_pkg::t_orient                   n_pending;
    logic [tod_pkg::COUNT_W-1:0]        r_agree_cnt;
    logic [tod_pkg::COUNT_W-1:0]        n_agree_cnt;

    // Result register
    logic                               r_out_valid;
    logic signed [tod_pkg::AXIS_W-1:0]  r_out_x, r_out_y, r_out_z;
    tod_pkg::t_orient                   r_out_cand;
    logic                               r_out_commit;

    tod_pkg::t_orient                   w_cand;
    logic                               n_commit;
    logic signed [tod_pkg::AXIS_W:0]    w_x_ext;
    logic signed [tod_pkg::AXIS_W:0]    w_y_ext;
    logic signed [tod_pkg::AXIS_W:0]    w_tilt_pos;
    logic signed [tod_pkg::AXIS_W:0]    w_tilt_neg;
    logic signed [tod_pkg::AXIS_W:0]    w_upside_pos;

    // Pipe control: each stage moves when the stage after it has room
    logic w_out_free, w_s2_adv, w_s2_free, w_s1_adv, w_s1_free, w_in_take;

    assign w_out_free = !r_out_valid || o_result.ready;
    assign w_s2_adv   = r_s2_valid && w_out_free;
    assign w_s2_free  = !r_s2_valid || w_out_free;
    assign w_s1_adv   = r_s1_valid && w_s2_free;
    assign w_s1_free  = !r_s1_valid || w_s2_free;
    assign w_in_take  = i_sample.valid && w_s1_free;

    assign i_sample.ready = w_s1_free;

    // Configuration writes; an index beyond the register list is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_thresh   <= tod_pkg::TILT_THRESH_RST;
            r_upside_thresh <= tod_pkg::UPSIDE_THRESH_RST;
            r_confirm_cnt   <= tod_pkg::CONFIRM_CNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tod_pkg::CFG_TILT_THRESH: begin
                    r_tilt_thresh <= i_cfg_wdata;
                end
                tod_pkg::CFG_UPSIDE_THRESH: begin
                    r_upside_thresh <= i_cfg_wdata;
                end
                tod_pkg::CFG_CONFIRM_CNT: begin
                    r_confirm_cnt <= i_cfg_wdata[tod_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Stage 1: capture the sample request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_s1_x <= i_sample.accel_x;
            r_s1_y <= i_sample.accel_y;
            r_s1_z <= i_sample.accel_z;
        end
    end

    // Stage 2: one low-pass step per axis against the running state
    tod_axis_filter u_filt_x (.i_old(r_filt_x), .i_sample(r_s1_x), .o_new(n_filt_x));
    tod_axis_filter u_filt_y (.i_old(r_filt_y), .i_sample(r_s1_y), .o_new(n_filt_y));
    tod_axis_filter u_filt_z (.i_old(r_filt_z), .i_sample(r_s1_z), .o_new(n_filt_z));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_filt_x   <= '0;
            r_filt_y   <= '0;
            r_filt_z   <= '0;
        end else begin
            if (w_s2_free) begin
                r_s2_valid <= r_s1_valid;
            end
            // Advance the filter state only when a sample moves into stage 2
            if (w_s1_adv) begin
                r_filt_x <= n_filt_x;
                r_filt_y <= n_filt_y;
                r_filt_z <= n_filt_z;
            end
        end
    end

    // Classify the filtered X and Y against the thresholds
    assign w_x_ext      = (tod_pkg::AXIS_W + 1)'(r_filt_x);
    assign w_y_ext      = (tod_pkg::AXIS_W + 1)'(r_filt_y);
    assign w_tilt_pos   = $signed({2'b00, r_tilt_thresh});
    assign w_tilt_neg   = -w_tilt_pos;
    assign w_upside_pos = $signed({2'b00, r_upside_thresh});

    always_comb begin
        if (w_x_ext > w_tilt_pos) begin
            w_cand = tod_pkg::ORIENT_POS_SIDE;
        end else if (w_x_ext < w_tilt_neg) begin
            w_cand = tod_pkg::ORIENT_NEG_SIDE;
        end else if (w_y_ext > w_upside_pos) begin
            w_cand = tod_pkg::ORIENT_UPSIDE;
        end else begin
            w_cand = tod_pkg::ORIENT_LANDSCAPE;
        end
    end

    // Debounce: count agreeing samples, pulse commit once the count is reached,
    // then hold the counter saturated until the candidate changes
    always_comb begin
        n_pending   = r_pending;
        n_agree_cnt = r_agree_cnt;
        n_commit    = 1'b0;
        if (w_cand == r_pending) begin
            if (r_agree_cnt < r_confirm_cnt) begin
                n_agree_cnt = r_agree_cnt + 1'b1;
                n_commit    = (n_agree_cnt == r_confirm_cnt);
            end
        end else begin
            n_pending   = w_cand;
            n_agree_cnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= tod_pkg::ORIENT_LANDSCAPE;
            r_agree_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
            if (w_s2_adv) begin
                r_pending   <= n_pending;
                r_agree_cnt <= n_agree_cnt;
            end
        end
    end

    // Result register: hold while the result request is stalled
    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_out_x      <= r_filt_x;
            r_out_y      <= r_filt_y;
            r_out_z      <= r_filt_z;
            r_out_cand   <= w_cand;
            r_out_commit <= n_commit;
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.smooth_x  = r_out_x;
    assign o_result.smooth_y  = r_out_y;
    assign o_result.smooth_z  = r_out_z;
    assign o_result.candidate = r_out_cand;
    assign o_result.commit    = r_out_commit;

endmodule

`default_nettype wire

@@ dv/tb_tilt_orientation_detector_core.sv @@
`timescale 1ns / 1ps

module tb_tilt_orientation_detector_core;

    localparam int WATCHDOG_CYCLES = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int RANDOM_SEGMENTS = 10;
    localparam int SEGMENT_ITEMS   = 50;

    // Index past the end of the register map; the block must ignore writes to it
    localparam logic [tod_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

    typedef struct {
        logic signed [tod_pkg::AXIS_W-1:0] ax;
        logic signed [tod_pkg::AXIS_W-1:0] ay;
        logic signed [tod_pkg::AXIS_W-1:0] az;
    } t_accel;

    typedef struct {
        logic signed [tod_pkg::AXIS_W-1:0] sx;
        logic signed [tod_pkg::AXIS_W-1:0] sy;
        logic signed [tod_pkg::AXIS_W-1:0] sz;
        tod_pkg::t_orient                  orient;
        logic                              commit;
    } t_pose_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [tod_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tod_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    tod_sample_if sample_bus ();
    tod_result_if result_bus ();

    tilt_orientation_detector_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (sample_bus),
        .o_result    (result_bus)
    );

    // Sample requests waiting for the driver, and predicted results in order
    t_accel       pending_samples[$];
    t_pose_result predicted_poses[$];

    int n_queued;
    int n_results;
    int n_errors;
    int quiet_cycles;

    // Idle percentages for the sample sender and the result receiver
    int send_gap_pct;
    int stall_pct;

    // Set at the rising edge when the sample on the bus was taken
    logic sample_taken;
    t_accel next_sample;

    // Shadow of the configuration registers as the block should hold them
    int          tilt_lim;
    int          upside_lim;
    logic [3:0]  confirm_need;

    // Predicted filter and debounce state
    int               lp_x;
    int               lp_y;
    int               lp_z;
    tod_pkg::t_orient held_orient;
    logic [3:0]       hold_count;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Advance the filter and the debounce on one accepted sample and queue the result.
    task automatic filter_and_classify(input t_accel s);
        t_pose_result     r;
        tod_pkg::t_orient want;
        logic             fire;
        // Integer division truncates toward zero, as the block's divider must
        lp_x = (lp_x * 7 + $signed(s.ax) * 3) / 10;
        lp_y = (lp_y * 7 + $signed(s.ay) * 3) / 10;
        lp_z = (lp_z * 7 + $signed(s.az) * 3) / 10;
        if (lp_x > tilt_lim) begin
            want = tod_pkg::ORIENT_POS_SIDE;
        end else if (lp_x < -tilt_lim) begin
            want = tod_pkg::ORIENT_NEG_SIDE;
        end else if (lp_y > upside_lim) begin
            want = tod_pkg::ORIENT_UPSIDE;
        end else begin
            want = tod_pkg::ORIENT_LANDSCAPE;
        end
        fire = 1'b0;
        if (want == held_orient) begin
            // Hold the count once it has reached the target; pulse only on arrival
            if (hold_count < confirm_need) begin
                hold_count = hold_count + 4'd1;
                fire = (hold_count == confirm_need);
            end
        end else begin
            held_orient = want;
            hold_count = 4'd0;
        end
        r.sx = lp_x[tod_pkg::AXIS_W-1:0];
        r.sy = lp_y[tod_pkg::AXIS_W-1:0];
        r.sz = lp_z[tod_pkg::AXIS_W-1:0];
        r.orient = want;
        r.commit = fire;
        predicted_poses.push_back(r);
    endtask

    task automatic report_field(input string name, input logic signed [16:0] want_v,
                                input logic signed [16:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
            n_errors++;
        end
    endtask

    // Rising edge: take sample requests into the predictor, check results, run the watchdog.
    always @(posedge i_clk) begin : monitor
        t_pose_result want;
        t_accel       seen;
        logic         got_sample;
        logic         got_result;
        got_sample = i_rst_n && sample_bus.valid && sample_bus.ready;
        got_result = i_rst_n && result_bus.valid && result_bus.ready;
        sample_taken = got_sample;
        if (got_sample) begin
            seen.ax = sample_bus.accel_x;
            seen.ay = sample_bus.accel_y;
            seen.az = sample_bus.accel_z;
            filter_and_classify(seen);
        end
        if (got_result) begin
            n_results++;
            if (predicted_poses.size() == 0) begin
                $display("%0t: result with none expected: x %0d y %0d z %0d cand %0d commit %0d",
                         $time, result_bus.smooth_x, result_bus.smooth_y, result_bus.smooth_z,
                         result_bus.candidate, result_bus.commit);
                n_errors++;
            end else begin
                want = predicted_poses.pop_front();
                report_field("smooth_x", want.sx, result_bus.smooth_x);
                report_field("smooth_y", want.sy, result_bus.smooth_y);
                report_field("smooth_z", want.sz, result_bus.smooth_z);
                report_field("candidate", want.orient, result_bus.candidate);
                report_field("commit", want.commit, result_bus.commit);
            end
        end
        if (got_sample || got_result) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no request moved for %0d cycles", $time, WATCHDOG_CYCLES);
            $display("FAILURE");
            $finish;
        end
    end

    // Falling edge: present the next sample request once the current one is gone.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            sample_bus.valid <= 1'b0;
        end else if (!sample_bus.valid || sample_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                next_sample = pending_samples.pop_front();
                sample_bus.valid   <= 1'b1;
                sample_bus.accel_x <= next_sample.ax;
                sample_bus.accel_y <= next_sample.ay;
                sample_bus.accel_z <= next_sample.az;
            end else begin
                sample_bus.valid <= 1'b0;
            end
        end
    end

    // Falling edge: stall the result side at random.
    always @(negedge i_clk) begin
        result_bus.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic signed [tod_pkg::AXIS_W-1:0] sat16(input int v);
        if (v > 32767) return 16'sh7FFF;
        if (v < -32768) return 16'sh8000;
        return v[tod_pkg::AXIS_W-1:0];
    endfunction

    task automatic queue_sample(input int x, input int y, input int z);
        pending_samples.push_back('{sat16(x), sat16(y), sat16(z)});
        n_queued++;
    endtask

    // Hold until every queued sample has produced its result; returns on a falling edge.
    task automatic wait_idle();
        while (n_results < n_queued) @(negedge i_clk);
    endtask

    // Drive one register write at this falling edge; the caller drops the enable.
    task automatic write_reg(input logic [tod_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tod_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            tod_pkg::CFG_TILT_THRESH:   tilt_lim = int'(val);
            tod_pkg::CFG_UPSIDE_THRESH: upside_lim = int'(val);
            tod_pkg::CFG_CONFIRM_CNT:   confirm_need = val[tod_pkg::COUNT_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_pacing(input int seg);
        if (seg < 7) begin
            send_gap_pct = 14;
            stall_pct = 45;
        end else if (seg < 11) begin
            send_gap_pct = 45;
            stall_pct = 14;
        end else begin
            send_gap_pct = 0;
            stall_pct = 0;
        end
    endtask

    // A run of samples that sits in one orientation, with a little jitter on every axis.
    task automatic queue_pose_run();
        tod_pkg::t_orient kind;
        int               len;
        int               bx;
        int               by;
        int               bz;
        kind = tod_pkg::t_orient'($urandom_range(3));
        len = $urandom_range(24, 1);
        bx = int'($urandom_range(tilt_lim)) - tilt_lim / 2;
        by = int'($urandom_range(65535)) - 32768;
        bz = int'($urandom_range(65535)) - 32768;
        case (kind)
            tod_pkg::ORIENT_POS_SIDE:
                bx = $urandom_range(32767, (tilt_lim < 32767) ? tilt_lim + 1 : 32767);
            tod_pkg::ORIENT_NEG_SIDE:
                bx = -int'($urandom_range(32768, tilt_lim + 1));
            tod_pkg::ORIENT_UPSIDE:
                by = $urandom_range(32767, (upside_lim < 32767) ? upside_lim + 1 : 32767);
            default: by = int'($urandom_range(upside_lim + 32768)) - 32768;
        endcase
        repeat (len) begin
            queue_sample(bx + int'($urandom_range(400)) - 200,
                         by + int'($urandom_range(400)) - 200,
                         bz + int'($urandom_range(400)) - 200);
        end
    endtask

    function automatic int pick_threshold();
        int r;
        r = $urandom_range(9);
        if (r == 0) return 0;
        if (r == 1) return 32767;
        return $urandom_range(20000, 2000);
    endfunction

    initial begin : stimulus
        int         seg;
        int         first;
        logic [3:0] conf;
        i_rst_n = 1'b0;
        i_clk = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = tod_pkg::CFG_TILT_THRESH;
        i_cfg_wdata = '0;
        sample_bus.valid = 1'b0;
        sample_bus.accel_x = '0;
        sample_bus.accel_y = '0;
        sample_bus.accel_z = '0;
        result_bus.ready = 1'b0;
        sample_taken = 1'b0;
        n_queued = 0;
        n_results = 0;
        n_errors = 0;
        quiet_cycles = 0;
        tilt_lim = int'(tod_pkg::TILT_THRESH_RST);
        upside_lim = int'(tod_pkg::UPSIDE_THRESH_RST);
        confirm_need = tod_pkg::CONFIRM_CNT_RST;
        lp_x = 0;
        lp_y = 0;
        lp_z = 0;
        held_orient = tod_pkg::ORIENT_LANDSCAPE;
        hold_count = 4'd0;
        set_pacing(0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Defaults after reset: axis extremes, swinging through every orientation
        queue_sample(0, 0, 0);
        repeat (5) queue_sample(32767, 0, -32768);
        repeat (4) queue_sample(-32768, 32767, 32767);
        repeat (2) queue_sample(0, 32767, 0);
        queue_sample(-32768, -32768, -32768);
        queue_sample(32767, 32767, 32767);
        wait_idle();

        // Zero thresholds, confirm on the first agreeing sample; upper data bits and
        // the spare index must be dropped
        write_reg(tod_pkg::CFG_TILT_THRESH, 15'd0);
        write_reg(tod_pkg::CFG_UPSIDE_THRESH, 15'd0);
        write_reg(tod_pkg::CFG_CONFIRM_CNT, 15'h7FF1);
        write_reg(CFG_IDX_SPARE, 15'h7FFF);
        i_cfg_we <= 1'b0;
        queue_sample(0, 0, 0);
        queue_sample(0, 0, 0);
        queue_sample(-1, -1, -1);
        queue_sample(1, 1, 1);
        wait_idle();

        // Thresholds at the top: only landscape is reachable; saturate the counter at 15
        write_reg(tod_pkg::CFG_TILT_THRESH, 15'h7FFF);
        write_reg(tod_pkg::CFG_UPSIDE_THRESH, 15'h7FFF);
        write_reg(tod_pkg::CFG_CONFIRM_CNT, 15'd15);
        i_cfg_we <= 1'b0;
        repeat (18) queue_sample(32767, 32767, 0);
        wait_idle();

        // Lower the target below the held count: no pulse while the candidate holds
        write_reg(tod_pkg::CFG_CONFIRM_CNT, 15'd2);
        i_cfg_we <= 1'b0;
        repeat (4) queue_sample(32767, 32767, 0);
        wait_idle();

        for (seg = 4; seg < 4 + RANDOM_SEGMENTS; seg++) begin
            set_pacing(seg);
            // First random segment runs with a zero target, so nothing may commit
            conf = (seg == 4) ? 4'd0 :
                   ($urandom_range(4) == 0) ? 4'd15 : 4'($urandom_range(6, 1));
            write_reg(tod_pkg::CFG_TILT_THRESH, 15'(pick_threshold()));
            write_reg(tod_pkg::CFG_UPSIDE_THRESH, 15'(pick_threshold()));
            write_reg(tod_pkg::CFG_CONFIRM_CNT, {11'($urandom()), conf});
            write_reg(CFG_IDX_SPARE, 15'($urandom()));
            i_cfg_we <= 1'b0;
            first = n_queued;
            while (n_queued - first < SEGMENT_ITEMS) begin
                if ($urandom_range(99) < 80) begin
                    queue_pose_run();
                end else begin
                    // Noise burst over the full range of every axis
                    repeat ($urandom_range(3, 1)) begin
                        queue_sample(int'($urandom_range(65535)) - 32768,
                                     int'($urandom_range(65535)) - 32768,
                                     int'($urandom_range(65535)) - 32768);
                    end
                end
            end
            wait_idle();
        end

        // Let the pipe settle so a stray late result still gets flagged
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (n_errors == 0 && predicted_poses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tod_pkg.sv
rtl/core/tod_sample_if.sv
rtl/core/tod_result_if.sv
rtl/core/tod_axis_filter.sv
rtl/core/tilt_orientation_detector_core.sv
dv/tb_tilt_orientation_detector_core.sv
